/* hdl/prfs_pkg.sv */
// Package for the point rotation pipeline: widths, turn constants, reciprocals
// and stage numbering. No dependencies.
package prfs_pkg;

  localparam int TRIG_FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int ANG_W   = 24;

  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;

  // one turn = TURN_ODD * 2^TURN_LOW_W
  localparam int TURN_LOW_W = 11;
  localparam int TURN_ODD   = 45;
  localparam int NEG_W      = ANG_W + 1;
  localparam int V45_W      = 14;
  localparam int OFS45      = TURN_ODD * 92;
  localparam int S45        = 20;
  localparam int K45_W      = 15;
  localparam logic [K45_W-1:0] K45 = K45_W'(((1 << S45) + TURN_ODD - 1) / TURN_ODD);
  localparam int PROD45_W   = V45_W + K45_W;
  localparam int Q45_W      = PROD45_W - S45;
  localparam int REM45_W    = 6;
  localparam int R0_W       = REM45_W + TURN_LOW_W;
  localparam int RW         = R0_W + 1;
  localparam int MAG_W      = 16;
  localparam int MAGP_W     = 2 * MAG_W;

  // m = floor(p * 2^F / (2^DEN_SHIFT * DEN_ODD)), p = a * (HALF_TURN - a)
  localparam int PW         = 30;
  localparam int DEN_SHIFT  = 18;
  localparam int DEN_ODD    = 2025;
  localparam int PD_SH      = (TRIG_FRAC_BITS >= DEN_SHIFT) ? 0 : DEN_SHIFT - TRIG_FRAC_BITS;
  localparam int K_SH       = (TRIG_FRAC_BITS >= DEN_SHIFT) ? TRIG_FRAC_BITS - DEN_SHIFT : 0;
  localparam int S2025      = 41;
  localparam int K2025_W    = 31;
  localparam logic [K2025_W-1:0] K2025 =
    K2025_W'(((64'd1 << S2025) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));
  localparam int QX_W       = PW + K2025_W;
  localparam int Q0_W       = 19;
  localparam int RM0_W      = 11;
  localparam int FRX_W      = RM0_W + K_SH;
  localparam int FX_W       = FRX_W + K2025_W;
  localparam int MQ_W       = Q0_W + K_SH;

  // sine magnitude and refinement, 9/40 = 9 / 2^3 / 5
  localparam int MW         = TRIG_FRAC_BITS + 1;
  localparam int TW         = TRIG_FRAC_BITS + 2;
  localparam int MM_W       = 2 * MW;
  localparam int REFINE_NUM = 9;
  localparam int REFINE_SH  = 3;
  localparam int REFINE_ODD = 5;
  localparam int D9_W       = MW + 4;
  localparam int X5_W       = TRIG_FRAC_BITS + 2;
  localparam int S5         = TRIG_FRAC_BITS + 6;
  localparam int K5_W       = TRIG_FRAC_BITS + 4;
  localparam logic [K5_W-1:0] K5 =
    K5_W'(((64'd1 << S5) + 64'(REFINE_ODD) - 64'd1) / 64'(REFINE_ODD));
  localparam int P5_W       = X5_W + K5_W;

  // rotation
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PRD_W      = TW + DIFF_W;
  localparam int SUM_W      = PRD_W + 1;
  localparam int SHR_W      = SUM_W - TRIG_FRAC_BITS;
  localparam int RES_W      = SHR_W + 1;

  // stage numbering
  localparam int ST_SIN_FIRST = 5;
  localparam int ST_SIN_LAST  = 13;
  localparam int N_STAGES     = 16;

endpackage

/* hdl/point_rotate_fast_sine.sv */
// Top level of the point rotation pipeline: angle reduction, sine/cosine,
// rotation and saturation. Depends on prfs_pkg and prfs_sine.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per point:
//   point, pivot (signed Q16.16) and angle in degrees (signed Q15.8).
//   Output channel (out_valid/out_ready) returns the rotated point
//   (signed Q16.16, saturated) and a clipped flag, one per input, in order.
//   Pipeline: 16 stages lie between the input transaction and out_valid
//   (angle reduction, the multiplier chain of the sine approximation,
//   four rotation products, sum, shift and saturate).
//   Throughput: one transaction per cycle while out_ready stays high.
//   Stalls: each stage holds while its successor is full and blocked;
//   empty stages keep filling, so in_ready stays high until the pipeline
//   is full behind a stalled output.
//   Reset: rst_n (synchronous, active low) empties every stage; no
//   transaction is in flight afterwards.
module point_rotate_fast_sine (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [prfs_pkg::COORD_W-1:0]    in_point_x,
  input  logic signed [prfs_pkg::COORD_W-1:0]    in_point_y,
  input  logic signed [prfs_pkg::COORD_W-1:0]    in_pivot_x,
  input  logic signed [prfs_pkg::COORD_W-1:0]    in_pivot_y,
  input  logic signed [prfs_pkg::ANG_W-1:0]      in_angle_deg,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [prfs_pkg::COORD_W-1:0]    out_rotated_x,
  output logic signed [prfs_pkg::COORD_W-1:0]    out_rotated_y,
  output logic                                   out_clipped
);
  import prfs_pkg::*;

  logic [N_STAGES+1:1] en;
  logic [N_STAGES:1]   vld_r;
  logic [N_STAGES:1]   vld_prev;

  logic signed [DIFF_W-1:0]  dx_r [1:ST_SIN_LAST];
  logic signed [DIFF_W-1:0]  dy_r [1:ST_SIN_LAST];
  logic signed [COORD_W-1:0] cx_r [1:N_STAGES-1];
  logic signed [COORD_W-1:0] cy_r [1:N_STAGES-1];

  logic signed [NEG_W-1:0]    neg;
  logic signed [NEG_W-1:0]    neg_sh;
  logic [V45_W-1:0]           v45_r;
  logic [V45_W-1:0]           v45_2_r;
  logic [TURN_LOW_W-1:0]      low_r;
  logic [TURN_LOW_W-1:0]      low_2_r;
  logic [PROD45_W-1:0]        prod45_r;
  logic [Q45_W-1:0]           q45;
  logic [REM45_W-1:0]         rem45;
  logic [R0_W-1:0]            r0;
  logic signed [RW-1:0]       r_nxt;
  logic signed [RW-1:0]       r_r;
  logic signed [RW-1:0]       rc_raw;
  logic signed [RW-1:0]       rc;
  logic [MAG_W-1:0]           as_r;
  logic [MAG_W-1:0]           ac_r;
  logic                       ns_r;
  logic                       nc_r;
  logic signed [TW-1:0]       sin_v;
  logic signed [TW-1:0]       cos_v;
  logic signed [PRD_W-1:0]    cdx_r;
  logic signed [PRD_W-1:0]    sdy_r;
  logic signed [PRD_W-1:0]    sdx_r;
  logic signed [PRD_W-1:0]    cdy_r;
  logic signed [SUM_W-1:0]    sx_r;
  logic signed [SUM_W-1:0]    sy_r;
  logic signed [RES_W-1:0]    rx;
  logic signed [RES_W-1:0]    ry;
  logic                       ovx;
  logic                       ovy;
  logic signed [COORD_W-1:0]  rx_sat;
  logic signed [COORD_W-1:0]  ry_sat;
  logic signed [COORD_W-1:0]  rot_x_r;
  logic signed [COORD_W-1:0]  rot_y_r;
  logic                       clip_r;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[N_STAGES+1] = out_ready;
    for (int i = N_STAGES; i >= 1; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign vld_prev = {vld_r[N_STAGES-1:1], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 1; i <= N_STAGES; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_prev[i];
        end
      end
    end
  end

  always_comb begin
    neg    = -NEG_W'(in_angle_deg);
    neg_sh = neg >>> TURN_LOW_W;
    q45    = Q45_W'(prod45_r >> S45);
    rem45  = REM45_W'(v45_2_r - V45_W'(q45) * V45_W'(TURN_ODD));
    r0     = {rem45, low_2_r};
    r_nxt  = (r0 > R0_W'(HALF_TURN)) ? RW'(r0) - RW'(FULL_TURN) : RW'(r0);
    rc_raw = r_r + RW'(QUARTER_TURN);
    rc     = (rc_raw > RW'(HALF_TURN)) ? rc_raw - RW'(FULL_TURN) : rc_raw;
    rx     = RES_W'(SHR_W'(sx_r >>> TRIG_FRAC_BITS)) + RES_W'(cx_r[N_STAGES-1]);
    ry     = RES_W'(SHR_W'(sy_r >>> TRIG_FRAC_BITS)) + RES_W'(cy_r[N_STAGES-1]);
    ovx    = (rx[RES_W-1:COORD_W-1] != '0) && (rx[RES_W-1:COORD_W-1] != '1);
    ovy    = (ry[RES_W-1:COORD_W-1] != '0) && (ry[RES_W-1:COORD_W-1] != '1);
    rx_sat = ovx ? (rx[RES_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}})
                 : COORD_W'(rx);
    ry_sat = ovy ? (ry[RES_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}})
                 : COORD_W'(ry);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx_r[1]  <= DIFF_W'(in_point_x) - DIFF_W'(in_pivot_x);
      dy_r[1]  <= DIFF_W'(in_pivot_y) - DIFF_W'(in_point_y);
      cx_r[1]  <= in_pivot_x;
      cy_r[1]  <= in_pivot_y;
      v45_r    <= V45_W'(neg_sh) + V45_W'(OFS45);
      low_r    <= neg[TURN_LOW_W-1:0];
    end
    for (int i = 2; i <= ST_SIN_LAST; i++) begin
      if (en[i]) begin
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
      end
    end
    for (int i = 2; i <= N_STAGES - 1; i++) begin
      if (en[i]) begin
        cx_r[i] <= cx_r[i-1];
        cy_r[i] <= cy_r[i-1];
      end
    end
    if (en[2]) begin
      prod45_r <= PROD45_W'(v45_r) * PROD45_W'(K45);
      v45_2_r  <= v45_r;
      low_2_r  <= low_r;
    end
    if (en[3]) begin
      r_r <= r_nxt;
    end
    if (en[4]) begin
      as_r <= MAG_W'(r_r[RW-1] ? -r_r : r_r);
      ns_r <= r_r[RW-1];
      ac_r <= MAG_W'(rc[RW-1] ? -rc : rc);
      nc_r <= rc[RW-1];
    end
    if (en[ST_SIN_LAST+1]) begin
      cdx_r <= PRD_W'(cos_v) * PRD_W'(dx_r[ST_SIN_LAST]);
      sdy_r <= PRD_W'(sin_v) * PRD_W'(dy_r[ST_SIN_LAST]);
      sdx_r <= PRD_W'(sin_v) * PRD_W'(dx_r[ST_SIN_LAST]);
      cdy_r <= PRD_W'(cos_v) * PRD_W'(dy_r[ST_SIN_LAST]);
    end
    if (en[ST_SIN_LAST+2]) begin
      sx_r <= SUM_W'(cdx_r) - SUM_W'(sdy_r);
      sy_r <= -SUM_W'(sdx_r) - SUM_W'(cdy_r);
    end
    if (en[N_STAGES]) begin
      rot_x_r <= rx_sat;
      rot_y_r <= ry_sat;
      clip_r  <= ovx || ovy;
    end
  end

  prfs_sine u_sin (
    .clk  (clk),
    .en   (en[ST_SIN_LAST:ST_SIN_FIRST]),
    .mag  (as_r),
    .neg  (ns_r),
    .sine (sin_v)
  );

  prfs_sine u_cos (
    .clk  (clk),
    .en   (en[ST_SIN_LAST:ST_SIN_FIRST]),
    .mag  (ac_r),
    .neg  (nc_r),
    .sine (cos_v)
  );

  assign in_ready      = en[1];
  assign out_valid     = vld_r[N_STAGES];
  assign out_rotated_x = rot_x_r;
  assign out_rotated_y = rot_y_r;
  assign out_clipped   = clip_r;

endmodule

/* hdl/prfs_sine.sv */
// Pipelined parabolic sine with refinement, stages ST_SIN_FIRST..ST_SIN_LAST.
// Takes angle magnitude and sign; depends on prfs_pkg.
module prfs_sine (
  input  logic                                                clk,
  input  logic [prfs_pkg::ST_SIN_LAST:prfs_pkg::ST_SIN_FIRST] en,
  input  logic [prfs_pkg::MAG_W-1:0]                          mag,
  input  logic                                                neg,
  output logic signed [prfs_pkg::TW-1:0]                      sine
);
  import prfs_pkg::*;

  logic [ST_SIN_LAST-1:ST_SIN_FIRST] neg_r;

  logic [MAGP_W-1:0]       p_full;
  logic [PW-1:0]           p_r;
  logic [PW-1:0]           pd_nxt;
  logic [PW-1:0]           pd_r;
  logic [QX_W-1:0]         qx_r;
  logic [Q0_W-1:0]         q0_nxt;
  logic [Q0_W-1:0]         q0_r;
  logic [Q0_W-1:0]         q0_8_r;
  logic [RM0_W-1:0]        rem0_r;
  logic [FRX_W-1:0]        frx;
  logic [FX_W-1:0]         fx_r;
  logic [MW-1:0]           m_nxt;
  logic [MW-1:0]           m9_r;
  logic [MW-1:0]           m10_r;
  logic [MW-1:0]           m11_r;
  logic [MW-1:0]           m12_r;
  logic [MM_W-1:0]         mm_r;
  logic [MW-1:0]           m2;
  logic [MW-1:0]           d;
  logic [D9_W-1:0]         d9;
  logic [X5_W-1:0]         x5_r;
  logic [P5_W-1:0]         p5_r;
  logic [MW-1:0]           t;
  logic [MW-1:0]           mp;
  logic signed [TW-1:0]    sine_r;

  always_comb begin
    p_full = MAGP_W'(mag) * MAGP_W'(MAG_W'(HALF_TURN) - mag);
    pd_nxt = p_r >> PD_SH;
    q0_nxt = Q0_W'(qx_r >> S2025);
    frx    = FRX_W'(rem0_r) << K_SH;
    m_nxt  = MW'((MQ_W'(q0_8_r) << K_SH) + MQ_W'(fx_r >> S2025));
    m2     = MW'(mm_r >> TRIG_FRAC_BITS);
    d      = m10_r - m2;
    d9     = D9_W'(d) * D9_W'(REFINE_NUM);
    t      = MW'(p5_r >> S5);
    mp     = m12_r - t;
  end

  always_ff @(posedge clk) begin
    if (en[ST_SIN_FIRST]) begin
      p_r                 <= p_full[PW-1:0];
      neg_r[ST_SIN_FIRST] <= neg;
    end
    for (int i = ST_SIN_FIRST + 1; i < ST_SIN_LAST; i++) begin
      if (en[i]) begin
        neg_r[i] <= neg_r[i-1];
      end
    end
    if (en[ST_SIN_FIRST+1]) begin
      pd_r <= pd_nxt;
      qx_r <= QX_W'(pd_nxt) * QX_W'(K2025);
    end
    if (en[ST_SIN_FIRST+2]) begin
      q0_r   <= q0_nxt;
      rem0_r <= RM0_W'(pd_r - PW'(q0_nxt) * PW'(DEN_ODD));
    end
    if (en[ST_SIN_FIRST+3]) begin
      q0_8_r <= q0_r;
      fx_r   <= FX_W'(frx) * FX_W'(K2025);
    end
    if (en[ST_SIN_FIRST+4]) begin
      m9_r <= m_nxt;
    end
    if (en[ST_SIN_FIRST+5]) begin
      mm_r  <= MM_W'(m9_r) * MM_W'(m9_r);
      m10_r <= m9_r;
    end
    if (en[ST_SIN_FIRST+6]) begin
      x5_r  <= X5_W'(d9 >> REFINE_SH);
      m11_r <= m10_r;
    end
    if (en[ST_SIN_FIRST+7]) begin
      p5_r  <= P5_W'(x5_r) * P5_W'(K5);
      m12_r <= m11_r;
    end
    if (en[ST_SIN_LAST]) begin
      sine_r <= neg_r[ST_SIN_LAST-1] ? -TW'(mp) : TW'(mp);
    end
  end

  assign sine = sine_r;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for point_rotate_fast_sine: table-driven and random point rotations
// checked against a fixed-point predictor, with random stalls on both channels.
// Depends on prfs_pkg and the point_rotate_fast_sine RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CW             = prfs_pkg::COORD_W;
  localparam int     AW             = prfs_pkg::ANG_W;
  localparam int     FRAC           = prfs_pkg::TRIG_FRAC_BITS;
  localparam longint TURN_UNITS     = prfs_pkg::FULL_TURN;
  localparam longint HALF_UNITS     = prfs_pkg::HALF_TURN;
  localparam longint QUARTER_UNITS  = prfs_pkg::QUARTER_TURN;
  localparam longint PARABOLA_DEN   = HALF_UNITS * HALF_UNITS;
  localparam longint COORD_MAX      = 64'sd2147483647;
  localparam longint COORD_MIN      = -64'sd2147483648;
  localparam int     LATENCY        = 16;
  localparam int     STALL_CYCLES   = 300;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     RANDOM_POINTS  = 1250;
  localparam int     ROWS           = 20;

  typedef struct packed {
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    logic          clip;
  } rotated_t;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [AW-1:0] ang;
    logic          known;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic          eclip;
  } vec_t;

  localparam vec_t DIRECTED [ROWS] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 24'h000000, 1'b1,
      32'h00000000, 32'h00000000, 1'b0},
    '{32'h12345678, 32'hF5432110, 32'h7FFFFFFF, 32'h80000000, 24'h000000, 1'b1,
      32'h12345678, 32'hF5432110, 1'b0},
    '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 24'h016800, 1'b1,
      32'h7FFFFFFF, 32'h80000000, 1'b0},
    '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 24'h00B400, 1'b1,
      32'h7FFFFFFF, 32'h80000000, 1'b1},
    '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 24'hFF4C00, 1'b1,
      32'h80000000, 32'h7FFFFFFF, 1'b1},
    '{32'h00030000, 32'h00050000, 32'h00010000, 32'h00020000, 24'h00B400, 1'b1,
      32'hFFFF0000, 32'hFFFF0000, 1'b0},
    '{32'h00010000, 32'h00000000, 32'h00000000, 32'h00000000, 24'h005A00, 1'b1,
      32'h00000000, 32'h00010000, 1'b0},
    '{32'h00010000, 32'h00000000, 32'h00000000, 32'h00000000, 24'hFFA600, 1'b1,
      32'h00000000, 32'hFFFF0000, 1'b0},
    '{32'h00000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'h005A00, 1'b1,
      32'h7FFFFFFF, 32'h00000000, 1'b1},
    '{32'h7FFFFFFF, 32'h00000000, 32'h80000000, 32'h00000000, 24'hFFA600, 1'b1,
      32'h80000000, 32'h80000000, 1'b1},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 24'h7FFFFF, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'h800000, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h00640000, 32'hFF9C0000, 32'h00000000, 32'h00000000, 24'h000001, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h00640000, 32'hFF9C0000, 32'h00000000, 32'h00000000, 24'hFFFFFF, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h01000000, 32'h00000000, 32'h00000000, 32'h00000000, 24'h002D00, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 32'h00000001, 24'h00B3FF, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 24'hFF4C01, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9, 32'h87654321, 24'h0059FF, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000, 32'h00000000, 24'h008700, 1'b0,
      32'h0, 32'h0, 1'b0},
    '{32'h00010000, 32'h00020000, 32'h00008000, 32'hFFFF8000, 24'h001E00, 1'b0,
      32'h0, 32'h0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] in_point_x;
  logic signed [CW-1:0] in_point_y;
  logic signed [CW-1:0] in_pivot_x;
  logic signed [CW-1:0] in_pivot_y;
  logic signed [AW-1:0] in_angle_deg;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CW-1:0] out_rotated_x;
  logic signed [CW-1:0] out_rotated_y;
  logic                 out_clipped;

  rotated_t pending_rotations [$];
  int       mismatches    = 0;
  int       quiet_cycles  = 0;
  bit       calm          = 1'b0;
  bit       stall_request = 1'b0;

  point_rotate_fast_sine i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_pivot_x   (in_pivot_x),
    .in_pivot_y   (in_pivot_y),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_clipped  (out_clipped)
  );

  always #1 clk = ~clk;

  function automatic longint parabolic_sine(longint r);
    longint mag;
    longint sq;
    mag = (r < 0) ? -r : r;
    if (mag > HALF_UNITS) mag = HALF_UNITS;
    mag = ((4 * mag * (HALF_UNITS - mag)) <<< FRAC) / PARABOLA_DEN;
    sq  = (mag * mag) >>> FRAC;
    mag = mag - ((mag - sq) * 9) / 40;
    return (r < 0) ? -mag : mag;
  endfunction

  function automatic logic [CW:0] clamp_coord(longint v);
    if (v > COORD_MAX) return {1'b1, 32'h7FFFFFFF};
    if (v < COORD_MIN) return {1'b1, 32'h80000000};
    return {1'b0, v[CW-1:0]};
  endfunction

  function automatic rotated_t rotate_about_pivot(vec_t v);
    longint   ang;
    longint   r;
    longint   rc;
    longint   s;
    longint   c;
    longint   cx;
    longint   cy;
    longint   dx;
    longint   dy;
    logic [CW:0] sx;
    logic [CW:0] sy;
    rotated_t res;
    ang = longint'($signed(v.ang));
    cx  = longint'($signed(v.cx));
    cy  = longint'($signed(v.cy));
    r   = (-ang) % TURN_UNITS;
    if (r < 0) r += TURN_UNITS;
    if (r > HALF_UNITS) r -= TURN_UNITS;
    rc = r + QUARTER_UNITS;
    if (rc > HALF_UNITS) rc -= TURN_UNITS;
    s  = parabolic_sine(r);
    c  = parabolic_sine(rc);
    dx = longint'($signed(v.px)) - cx;
    dy = cy - longint'($signed(v.py));
    sx = clamp_coord(cx + ((c * dx - s * dy) >>> FRAC));
    sy = clamp_coord(cy + ((-(s * dx) - c * dy) >>> FRAC));
    res.rx   = sx[CW-1:0];
    res.ry   = sy[CW-1:0];
    res.clip = sx[CW] | sy[CW];
    return res;
  endfunction

  function automatic logic [CW-1:0] random_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 32'($signed(22'($urandom)));
      5, 6:          return 32'($signed(28'($urandom)));
      7, 8:          return $urandom;
      default:       return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                              : 32'h80000000 + $urandom_range(3);
    endcase
  endfunction

  function automatic logic [AW-1:0] random_angle();
    case ($urandom_range(3))
      0, 1:    return AW'($urandom);
      2:       return AW'($signed(16'($urandom)));
      default: return AW'((int'($urandom_range(728)) - 364) * int'(QUARTER_UNITS)
                          + int'($urandom_range(4)) - 2);
    endcase
  endfunction

  task automatic send_point(input vec_t v);
    in_valid     <= 1'b1;
    in_point_x   <= v.px;
    in_point_y   <= v.py;
    in_pivot_x   <= v.cx;
    in_pivot_y   <= v.cy;
    in_angle_deg <= v.ang;
    do @(posedge clk); while (!in_ready);
    if (v.known) pending_rotations.push_back('{v.ex, v.ey, v.eclip});
    else pending_rotations.push_back(rotate_about_pivot(v));
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input rotated_t want, input rotated_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp x=%h y=%h clip=%b, got x=%h y=%h clip=%b", $realtime, what,
               want.rx, want.ry, want.clip, got.rx, got.ry, got.clip);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    rotated_t got;
    rotated_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_rotated_x, out_rotated_y, out_clipped};
      if (pending_rotations.size() == 0) begin
        note_mismatch("unexpected transaction", '0, got);
      end else begin
        want = pending_rotations.pop_front();
        if (got.rx !== want.rx || got.ry !== want.ry || got.clip !== want.clip)
          note_mismatch("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    vec_t item;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_point_x   <= '0;
    in_point_y   <= '0;
    in_pivot_x   <= '0;
    in_pivot_y   <= '0;
    in_angle_deg <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) send_point(DIRECTED[i]);
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      calm = (n >= 300 && n < 600);
      if (n == 700) stall_request = 1'b1;
      if (n == 1000) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_rotations.size() != 0);
      end
      item     = '0;
      item.px  = random_coord();
      item.py  = random_coord();
      item.cx  = random_coord();
      item.cy  = random_coord();
      item.ang = random_angle();
      send_point(item);
    end
    in_valid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_rotations.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
